/* design/bra_pkg.sv */
// Shared types, constants and helpers of the bus request arbiter.
`default_nettype none
package bra_pkg;

	localparam int PRODUCERS   = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int PROD_W      = 3;
	localparam int OWN_W       = PROD_W + 1;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int PRIO_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [OWN_W-1:0] NO_OWNER = OWN_W'(PRODUCERS);

	localparam logic [1:0] MODE_REQUEST = 2'd0;
	localparam logic [1:0] MODE_GRANT   = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_RR   = 2'd1;
	localparam logic [1:0] POL_PRIO = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STARVE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_TBL  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] PRIO_TBL_RST = 64'h0706050403020100;

	typedef struct packed {
		logic [1:0]        mode;
		logic [PROD_W-1:0] producer;
		logic [TIME_W-1:0] now_ticks;
		logic [TIME_W-1:0] hold_ticks;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              grant_valid;
		logic [PROD_W-1:0] grant_producer;
		logic [TIME_W-1:0] bus_wait;
		logic              busy_res;
		logic [CNT_W-1:0]  queue_depth;
		logic [TIME_W-1:0] oldest_age;
		logic [CNT_W-1:0]  peak_depth;
		logic [TIME_W-1:0] producer_overflows;
		logic [CNT_W-1:0]  producer_pending;
		logic [TIME_W-1:0] producer_max_wait;
		logic [TIME_W-1:0] producer_starved;
	} res_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic              rot;
		logic              del;
		logic [QIDX_W-1:0] del_idx;
		logic              wr;
		logic [QIDX_W-1:0] wr_idx;
	} cell_ctl_t;

	typedef struct packed {
		logic              enq;
		logic              ovf;
		logic              gnt;
		logic              starve;
		logic [TIME_W-1:0] wait_ticks;
	} stat_cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] ovf;
		logic [CNT_W-1:0]  pend;
		logic [TIME_W-1:0] maxw;
		logic [TIME_W-1:0] starv;
	} stat_rd_t;

	function automatic logic [PRIO_W-1:0] prio_of(input logic [CFG_DATA_W-1:0] tbl,
		input logic [PROD_W-1:0] p);
		prio_of = tbl[p*PRIO_W +: PRIO_W];
	endfunction

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		sat_inc = (v == '1) ? v : v + TIME_W'(1);
	endfunction

endpackage
`default_nettype wire

/* design/bra_cell.sv */
// One queue slot: loads from its upper neighbor on rotate/delete, or takes a new entry.
`default_nettype none
module bra_cell (
	input  logic               clk,
	input  bra_pkg::cell_ctl_t ctl,
	input  logic [bra_pkg::QIDX_W-1:0] pos,
	input  bra_pkg::entry_t    nbr,
	input  bra_pkg::entry_t    wr_ent,
	output bra_pkg::entry_t    ent
);
	bra_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			ent_q <= nbr;
		end else if (ctl.del && pos >= ctl.del_idx) begin
			ent_q <= nbr;
		end else if (ctl.wr && pos == ctl.wr_idx) begin
			ent_q <= wr_ent;
		end
	end

	assign ent = ent_q;
endmodule
`default_nettype wire

/* design/bra_stats.sv */
// Per-producer statistics counters with a single access index.
`default_nettype none
module bra_stats (
	input  logic               clk,
	input  logic               arst_n,
	input  bra_pkg::stat_cmd_t cmd,
	input  logic [bra_pkg::PROD_W-1:0] idx,
	output bra_pkg::stat_rd_t  rd
);
	logic [bra_pkg::TIME_W-1:0] ovf_q   [bra_pkg::PRODUCERS];
	logic [bra_pkg::CNT_W-1:0]  pend_q  [bra_pkg::PRODUCERS];
	logic [bra_pkg::TIME_W-1:0] maxw_q  [bra_pkg::PRODUCERS];
	logic [bra_pkg::TIME_W-1:0] starv_q [bra_pkg::PRODUCERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bra_pkg::PRODUCERS; i++) begin
				ovf_q[i]   <= '0;
				pend_q[i]  <= '0;
				maxw_q[i]  <= '0;
				starv_q[i] <= '0;
			end
		end else begin
			if (cmd.ovf) begin
				ovf_q[idx] <= bra_pkg::sat_inc(ovf_q[idx]);
			end
			if (cmd.enq) begin
				pend_q[idx] <= pend_q[idx] + bra_pkg::CNT_W'(1);
			end
			if (cmd.gnt) begin
				if (cmd.wait_ticks > maxw_q[idx]) begin
					maxw_q[idx] <= cmd.wait_ticks;
				end
				if (cmd.starve) begin
					starv_q[idx] <= bra_pkg::sat_inc(starv_q[idx]);
				end
				if (pend_q[idx] != '0) begin
					pend_q[idx] <= pend_q[idx] - bra_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign rd.ovf   = ovf_q[idx];
	assign rd.pend  = pend_q[idx];
	assign rd.maxw  = maxw_q[idx];
	assign rd.starv = starv_q[idx];
endmodule
`default_nettype wire

/* design/bus_request_arbiter.sv */
// Top level of the bus request arbiter: queue cell chain, sequencer and statistics.
//
// Usage
//   Command channel: an item (req) transfers when start is high and busy is low.
//   busy stays high while the item is worked on; no other item is taken then.
//   Each item yields one result on res, marked by done for exactly one cycle.
//   The receiver cannot stall: the result must be taken in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, index 3 is ignored. Write only while the block is idle.
// Timing
//   The queue is a row of 16 cells. Scans rotate the whole row one slot a
//   cycle so every entry passes the head cell once, which is where the
//   policy selection and the oldest-age search look.
//   Request, release, query: an age scan, then the output state raises done.
//   Grant that is made: pick scan, delete, age scan, then the output state.
//   A grant refused (bus held or queue empty) takes the age-scan-only path.
//   Next item may start in the cycle done is high.
// Reset
//   arst_n clears the count, peak, owner, previous grantee, hold times,
//   statistics and registers to their defaults; queue contents are not
//   cleared, only slots below the count are ever examined.
`default_nettype none
module bus_request_arbiter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  bra_pkg::req_t                     req,
	output logic                              done,
	output bra_pkg::res_t                     res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bra_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bra_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int QD = bra_pkg::QUEUE_DEPTH;

	typedef enum logic [2:0] {ST_IDLE, ST_PICK, ST_DEL, ST_AGE, ST_OUT} state_t;

	state_t state_q;

	// config registers
	logic [1:0]                     policy_q;
	logic [bra_pkg::TIME_W-1:0]     thr_q;
	logic [bra_pkg::CFG_DATA_W-1:0] prio_tbl_q;

	// arbiter state
	logic [bra_pkg::CNT_W-1:0]  count_q, peak_q;
	logic [bra_pkg::OWN_W-1:0]  owner_q, prev_q;
	logic [bra_pkg::TIME_W-1:0] hs_q, he_q;

	// latched item
	logic [bra_pkg::PROD_W-1:0]  prod_q;
	logic [bra_pkg::TIME_W-1:0]  now_q, hold_q;

	// scan state
	logic [bra_pkg::QIDX_W-1:0] k_q;
	logic                       found_q;
	logic [bra_pkg::QIDX_W-1:0] sel_idx_q;
	bra_pkg::entry_t            sel_ent_q;
	logic [bra_pkg::PRIO_W-1:0] best_pr_q;
	logic [bra_pkg::TIME_W-1:0] oldest_q;

	// per-item result pieces
	logic                        acc_q, gv_q;
	logic [bra_pkg::PROD_W-1:0]  gp_q;
	logic [bra_pkg::TIME_W-1:0]  wait_q;
	bra_pkg::res_t               res_q;
	logic                        done_q;

	// queue chain
	bra_pkg::entry_t    ents [QD];
	bra_pkg::cell_ctl_t cctl;
	bra_pkg::entry_t    wr_ent;

	bra_pkg::stat_cmd_t scmd;
	bra_pkg::stat_rd_t  srd;
	logic [bra_pkg::PROD_W-1:0] sidx;

	logic accept, is_req, q_full;
	logic held_in, head_valid, scan_end;
	bra_pkg::entry_t head;
	logic [bra_pkg::PRIO_W-1:0] head_pr;
	logic [bra_pkg::TIME_W-1:0] gnt_wait, head_age;

	assign accept     = start && (state_q == ST_IDLE);
	assign is_req     = accept && (req.mode == bra_pkg::MODE_REQUEST);
	assign q_full     = (count_q == bra_pkg::CNT_W'(QD));
	assign head       = ents[0];
	assign head_pr    = bra_pkg::prio_of(prio_tbl_q, head.prod);
	assign head_valid = {1'b0, k_q} < count_q;
	assign head_age   = now_q - head.stamp;
	assign scan_end   = (k_q == bra_pkg::QIDX_W'(QD - 1));
	assign gnt_wait   = now_q - sel_ent_q.stamp;
	// bus held test with wrap-safe elapsed times
	assign held_in    = (owner_q != bra_pkg::NO_OWNER) &&
		((req.now_ticks - hs_q) < (he_q - hs_q));

	assign wr_ent.prod  = req.producer;
	assign wr_ent.stamp = req.now_ticks;

	always_comb begin
		cctl.rot     = (state_q == ST_PICK) || (state_q == ST_AGE);
		cctl.del     = (state_q == ST_DEL);
		cctl.del_idx = sel_idx_q;
		cctl.wr      = is_req && !q_full;
		cctl.wr_idx  = count_q[bra_pkg::QIDX_W-1:0];
	end

	for (genvar i = 0; i < QD; i++) begin : g_cell
		localparam int NXT = (i + 1) % QD;
		bra_cell u_cell (
			.clk    (clk),
			.ctl    (cctl),
			.pos    (bra_pkg::QIDX_W'(i)),
			.nbr    (ents[NXT]),
			.wr_ent (wr_ent),
			.ent    (ents[i])
		);
	end

	// statistics: one index, switched between item producer and granted producer
	always_comb begin
		scmd.enq        = is_req && !q_full;
		scmd.ovf        = is_req && q_full;
		scmd.gnt        = (state_q == ST_DEL);
		scmd.wait_ticks = gnt_wait;
		scmd.starve     = (thr_q != '0) && (gnt_wait > thr_q);
		if (state_q == ST_DEL) begin
			sidx = sel_ent_q.prod;
		end else if (state_q == ST_IDLE) begin
			sidx = req.producer;
		end else begin
			sidx = prod_q;
		end
	end

	bra_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scmd),
		.idx    (sidx),
		.rd     (srd)
	);

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= bra_pkg::POL_FIFO;
			thr_q      <= '0;
			prio_tbl_q <= bra_pkg::PRIO_TBL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bra_pkg::REG_POLICY:   policy_q   <= cfg_data[1:0];
				bra_pkg::REG_STARVE:   thr_q      <= cfg_data[bra_pkg::TIME_W-1:0];
				bra_pkg::REG_PRIO_TBL: prio_tbl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			peak_q    <= '0;
			owner_q   <= bra_pkg::NO_OWNER;
			prev_q    <= bra_pkg::NO_OWNER;
			hs_q      <= '0;
			he_q      <= '0;
			k_q       <= '0;
			found_q   <= 1'b0;
			sel_idx_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prod_q  <= req.producer;
						now_q   <= req.now_ticks;
						hold_q  <= req.hold_ticks;
						acc_q   <= 1'b0;
						gv_q    <= 1'b0;
						gp_q    <= '0;
						wait_q  <= '0;
						k_q     <= '0;
						found_q <= 1'b0;
						oldest_q <= '0;
						sel_idx_q <= '0;
						state_q <= ST_AGE;
						unique case (req.mode)
							bra_pkg::MODE_REQUEST: begin
								if (!q_full) begin
									count_q <= count_q + bra_pkg::CNT_W'(1);
									if (count_q + bra_pkg::CNT_W'(1) > peak_q) begin
										peak_q <= count_q + bra_pkg::CNT_W'(1);
									end
									acc_q <= 1'b1;
								end
							end
							bra_pkg::MODE_GRANT: begin
								if (!held_in && count_q != '0) begin
									state_q <= ST_PICK;
								end
							end
							bra_pkg::MODE_RELEASE: owner_q <= bra_pkg::NO_OWNER;
							default: ;
						endcase
					end
				end
				ST_PICK: begin
					if (head_valid) begin
						case (policy_q)
							bra_pkg::POL_FIFO: begin
								if (k_q == '0) begin
									sel_ent_q <= head;
									sel_idx_q <= '0;
								end
							end
							bra_pkg::POL_RR: begin
								// first entry not from the last grantee, else the head
								if (!found_q && {1'b0, head.prod} != prev_q) begin
									sel_ent_q <= head;
									sel_idx_q <= k_q;
									found_q   <= 1'b1;
								end else if (k_q == '0) begin
									sel_ent_q <= head;
									sel_idx_q <= '0;
								end
							end
							default: begin
								if (k_q == '0 || head_pr < best_pr_q) begin
									sel_ent_q <= head;
									sel_idx_q <= k_q;
									best_pr_q <= head_pr;
								end
							end
						endcase
					end
					k_q <= k_q + bra_pkg::QIDX_W'(1);
					if (scan_end) begin
						state_q <= ST_DEL;
					end
				end
				ST_DEL: begin
					count_q <= count_q - bra_pkg::CNT_W'(1);
					owner_q <= {1'b0, sel_ent_q.prod};
					prev_q  <= {1'b0, sel_ent_q.prod};
					hs_q    <= now_q;
					he_q    <= now_q + hold_q;
					gv_q    <= 1'b1;
					gp_q    <= sel_ent_q.prod;
					wait_q  <= gnt_wait;
					k_q     <= '0;
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					if (head_valid && head_age > oldest_q) begin
						oldest_q <= head_age;
					end
					k_q <= k_q + bra_pkg::QIDX_W'(1);
					if (scan_end) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					res_q.accepted           <= acc_q;
					res_q.grant_valid        <= gv_q;
					res_q.grant_producer     <= gp_q;
					res_q.bus_wait           <= wait_q;
					res_q.busy_res           <= (owner_q != bra_pkg::NO_OWNER) &&
						((now_q - hs_q) < (he_q - hs_q));
					res_q.queue_depth        <= count_q;
					res_q.oldest_age         <= oldest_q;
					res_q.peak_depth         <= peak_q;
					res_q.producer_overflows <= srd.ovf;
					res_q.producer_pending   <= srd.pend;
					res_q.producer_max_wait  <= srd.maxw;
					res_q.producer_starved   <= srd.starv;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

/* design/bra_check.sv */
// Port-level checker for the bus request arbiter, bound to the top level.
`default_nettype none
module bra_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input bra_pkg::res_t                     res
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not start");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.accepted && res.grant_valid)) else $error("accept and grant together");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.queue_depth <= res.peak_depth) &&
		(res.peak_depth <= bra_pkg::CNT_W'(bra_pkg::QUEUE_DEPTH)))
		else $error("depth out of range");
endmodule

bind bus_request_arbiter bra_check u_bra_check (.*);
`default_nettype wire
